/* src/wdlc_pkg.sv */
// Shared types and fixed field widths of the window distinct letter counter.
// No dependencies; imported by the core and the letter bank.
package wdlc_pkg;

    localparam int CFG_BITS         = 7;   // window length config port width
    localparam int LETTER_BITS      = 5;   // letter port width
    localparam int OUT_TOTAL_BITS   = 16;  // match total port width
    localparam int WINDOW_LEN_RESET = 4;   // window length after reset

    // Per-word control from the top level to the letter count bank
    typedef struct packed {
        logic step;    // a word is accepted this cycle
        logic leave;   // the oldest letter drops out of the window
        logic clear;   // end of string or new window length
    } ctrl_t;

endpackage

/* src/window_distinct_letter_counter_core.sv */
// Top level of the window distinct letter counter: history cell chain,
// letter count bank, window control, match total and output register.
// Depends on wdlc_pkg, wdlc_hist_cell and wdlc_letter_bank.
//
//  channel  ports                                  direction  word
//  input    s_valid s_ready s_letter s_last        in         one letter
//  result   m_valid m_ready m_match m_match_total  out        one result
//           m_done_res
//  config   cfg_valid cfg_ready cfg_data           in         window length
//
// One word per cycle unless a stalled result holds s_ready low; the result
// appears in the next cycle via the tail tap, count bank and total adder.
// Reset: synchronous, active low; window length returns to 4, string cleared.
// A stalled result holds in the output register; s_ready is high whenever
// that register is empty or being taken.
// A config write clears the string state; cfg_ready is always high.
module window_distinct_letter_counter_core
    import wdlc_pkg::*;
#(
    parameter int WINDOW_MAX = 64,
    parameter int ALPHABET   = 26,
    parameter int TOTAL_BITS = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [LETTER_BITS-1:0]    s_letter,
    input  logic                      s_last,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_match,
    output logic [OUT_TOTAL_BITS-1:0] m_match_total,
    output logic                      m_done_res,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_BITS-1:0]       cfg_data
);

    localparam int LW      = $clog2(ALPHABET);
    localparam int KW      = $clog2(WINDOW_MAX + 1);
    localparam int DW      = $clog2(ALPHABET + 1);
    localparam int K_RESET = (WINDOW_LEN_RESET > WINDOW_MAX) ? WINDOW_MAX : WINDOW_LEN_RESET;

    logic [KW-1:0]         k_reg;
    logic [KW-1:0]         k_cfg;
    logic [KW-1:0]         fill_reg;
    logic [KW-1:0]         fill_next;
    logic [TOTAL_BITS-1:0] total_reg;
    logic [TOTAL_BITS-1:0] total_next;
    logic                  m_valid_reg;
    logic                  accept;
    logic                  cfg_fire;
    logic                  leave;
    logic                  match_next;
    logic [LW-1:0]         letter;
    logic [LW-1:0]         old_letter;
    logic [LW-1:0]         hist [WINDOW_MAX];
    logic [LW-1:0]         taps [WINDOW_MAX];
    logic [DW-1:0]         distinct_next;
    ctrl_t                 ctrl;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid;
    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;

    // clamp out-of-range codes to the last letter
    always_comb begin
        if (int'(s_letter) >= ALPHABET) begin
            letter = LW'(ALPHABET - 1);
        end else begin
            letter = LW'(s_letter);
        end
    end

    always_comb begin
        if (cfg_data == '0) begin
            k_cfg = KW'(1);
        end else if (int'(cfg_data) > WINDOW_MAX) begin
            k_cfg = KW'(WINDOW_MAX);
        end else begin
            k_cfg = KW'(cfg_data);
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < WINDOW_MAX; gi++) begin : g_cell
            wdlc_hist_cell #(
                .LW    (LW),
                .KW    (KW),
                .INDEX (gi)
            ) u_cell (
                .aclk  (aclk),
                .shift (accept),
                .d_in  ((gi == 0) ? letter : hist[(gi == 0) ? 0 : gi - 1]),
                .k     (k_reg),
                .q     (hist[gi]),
                .tap   (taps[gi])
            );
        end
    endgenerate

    // at most one cell drives its tap
    always_comb begin
        old_letter = '0;
        for (int i = 0; i < WINDOW_MAX; i++) begin
            old_letter = old_letter | taps[i];
        end
    end

    assign leave     = (fill_reg >= k_reg);
    assign fill_next = leave ? k_reg : fill_reg + KW'(1);

    assign ctrl.step  = accept;
    assign ctrl.leave = leave;
    assign ctrl.clear = cfg_fire || (accept && s_last);

    wdlc_letter_bank #(
        .ALPHABET   (ALPHABET),
        .WINDOW_MAX (WINDOW_MAX)
    ) u_bank (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctrl          (ctrl),
        .old_letter    (old_letter),
        .new_letter    (letter),
        .distinct_next (distinct_next)
    );

    assign match_next = (fill_next == k_reg) && (int'(distinct_next) == int'(k_reg) - 1);
    assign total_next = (match_next && (total_reg != '1)) ? total_reg + TOTAL_BITS'(1)
                                                         : total_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg       <= KW'(K_RESET);
            fill_reg    <= '0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_fire) begin
                k_reg     <= k_cfg;
                fill_reg  <= '0;
                total_reg <= '0;
            end else if (accept) begin
                if (s_last) begin
                    fill_reg  <= '0;
                    total_reg <= '0;
                end else begin
                    fill_reg  <= fill_next;
                    total_reg <= total_next;
                end
            end
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_match       <= match_next;
            m_match_total <= OUT_TOTAL_BITS'(total_next);
            m_done_res    <= s_last;
        end
    end

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= k_reg)
        else $error("window fill exceeds window length");

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_last && !cfg_fire) |=> (fill_reg == '0 && total_reg == '0))
        else $error("string state not cleared after last word");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid_reg)
        else $error("accepted word produced no result");

endmodule

/* src/wdlc_hist_cell.sv */
// One cell of the letter history shift line.
// Holds one letter, hands it to the next cell on each accepted word and
// drives its letter on the tap when it sits at the tail of the window.
module wdlc_hist_cell #(
    parameter int LW    = 5,
    parameter int KW    = 7,
    parameter int INDEX = 0
) (
    input  logic          aclk,
    input  logic          shift,
    input  logic [LW-1:0] d_in,
    input  logic [KW-1:0] k,
    output logic [LW-1:0] q,
    output logic [LW-1:0] tap
);

    logic [LW-1:0] letter_reg;
    logic          sel;

    always_ff @(posedge aclk) begin
        if (shift) begin
            letter_reg <= d_in;
        end
    end

    // cell INDEX holds the letter taken INDEX+1 words ago
    assign sel = (int'(k) == INDEX + 1);
    assign q   = letter_reg;
    assign tap = sel ? letter_reg : '0;

endmodule

/* src/wdlc_letter_bank.sv */
// Per-letter occurrence counters and the distinct letter count.
// Depends on wdlc_pkg (ctrl_t); every counter decodes its own letter index.
module wdlc_letter_bank
    import wdlc_pkg::*;
#(
    parameter int ALPHABET   = 26,
    parameter int WINDOW_MAX = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  ctrl_t                         ctrl,
    input  logic [$clog2(ALPHABET)-1:0]   old_letter,
    input  logic [$clog2(ALPHABET)-1:0]   new_letter,
    output logic [$clog2(ALPHABET+1)-1:0] distinct_next
);

    localparam int LW   = $clog2(ALPHABET);
    localparam int DW   = $clog2(ALPHABET + 1);
    localparam int CNTW = $clog2(WINDOW_MAX + 1);

    logic [CNTW-1:0] cnt_reg  [ALPHABET];
    logic [CNTW-1:0] cnt_next [ALPHABET];
    logic [ALPHABET-1:0] drop_flag;
    logic [ALPHABET-1:0] add_flag;
    logic [DW-1:0]       distinct_reg;
    logic [DW-1:0]       after_drop;

    always_comb begin
        for (int i = 0; i < ALPHABET; i++) begin
            logic is_old;
            logic is_new;
            logic dec;
            is_old = ctrl.leave && (old_letter == LW'(i));
            is_new = (new_letter == LW'(i));
            dec    = is_old && (cnt_reg[i] != '0);
            // a letter that leaves and comes back keeps its place in the count
            drop_flag[i] = is_old && (cnt_reg[i] == CNTW'(1)) && !is_new;
            add_flag[i]  = is_new && (cnt_reg[i] == '0);
            cnt_next[i]  = cnt_reg[i] + CNTW'(is_new) - CNTW'(dec);
        end
    end

    always_comb begin
        after_drop = distinct_reg;
        if ((|drop_flag) && (distinct_reg != '0)) begin
            after_drop = distinct_reg - DW'(1);
        end
        distinct_next = after_drop + DW'(|add_flag);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.clear) begin
            for (int i = 0; i < ALPHABET; i++) begin
                cnt_reg[i] <= '0;
            end
            distinct_reg <= '0;
        end else if (ctrl.step) begin
            for (int i = 0; i < ALPHABET; i++) begin
                cnt_reg[i] <= cnt_next[i];
            end
            distinct_reg <= distinct_next;
        end
    end

endmodule
